>>> sv/shape_overlap_push_unit_macros.svh
// assertion macros for the shape overlap push unit checker
`ifndef SHAPE_OVERLAP_PUSH_UNIT_MACROS_SVH
`define SHAPE_OVERLAP_PUSH_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define SOP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("shape overlap push unit check failed");

// next-cycle implication, sampled on clk, off during reset
`define SOP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("shape overlap push unit check failed");

`endif

>>> sv/sop_pkg.sv
// shared types, constants and saturation helper for the shape overlap push unit
package sop_pkg;

    localparam logic [1:0] FUNC_CC   = 2'd0;
    localparam logic [1:0] FUNC_CB   = 2'd1;
    localparam logic [1:0] FUNC_BB   = 2'd2;
    localparam logic [1:0] FUNC_NONE = 2'd3;

    localparam int SQ_N   = 32;
    localparam int DV_N   = 32;
    localparam int PIPE_N = SQ_N + DV_N + 4;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] a_x;
        logic [31:0] a_y;
        logic [30:0] a_w;
        logic [30:0] a_h;
        logic [31:0] b_x;
        logic [31:0] b_y;
        logic [30:0] b_w;
        logic [30:0] b_h;
        logic        want_push;
    } sop_in_t;

    typedef struct packed {
        logic        hit;
        logic [31:0] push_x;
        logic [31:0] push_y;
    } sop_out_t;

    typedef struct packed {
        logic        bypass;
        logic        hit_b;
        logic [31:0] px_b;
        logic [31:0] py_b;
        logic        circ;
        logic        want;
        logic        neg_x;
        logic        neg_y;
        logic [31:0] mx;
        logic [31:0] my;
        logic [31:0] r;
    } sop_job_t;

    typedef struct packed {
        sop_job_t    job;
        logic        chit;
        logic [32:0] dlen;
        logic        ovx;
        logic        ovy;
    } sop_trk_t;

    function automatic logic [31:0] sat32(input logic [35:0] mag, input logic neg);
        logic [31:0] res;
        if (neg) begin
            if (mag >= 36'h080000000)
                res = 32'h80000000;
            else
                res = ~mag[31:0] + 32'd1;
        end
        else if (mag > 36'h07FFFFFFF)
            res = 32'h7FFFFFFF;
        else
            res = mag[31:0];
        return res;
    endfunction

endpackage

>>> sv/sop_front.sv
// front end: classifies a shape pair, finishes box tests, reduces circle cases
module sop_front
    import sop_pkg::*;
(
    input  sop_in_t  item,
    output sop_job_t job
);

    function automatic logic [35:0] abs36(input logic signed [35:0] v);
        return v[35] ? 36'(-v) : 36'(v);
    endfunction

    logic signed [35:0] ax, ay, bx, by, aw, ah, bw, bh;
    logic signed [35:0] dx0, dy0, rs;
    logic signed [35:0] x0, x1, y0, y1, cx, cy, dx1, dy1;
    logic signed [35:0] ax2, ay2, bx2, by2, vx, vy;
    logic [35:0] mx0, my0, mx1, my1;
    logic far, bb_hit;
    logic [31:0] hpx, hpy;

    assign ax = {{4{item.a_x[31]}}, item.a_x};
    assign ay = {{4{item.a_y[31]}}, item.a_y};
    assign bx = {{4{item.b_x[31]}}, item.b_x};
    assign by = {{4{item.b_y[31]}}, item.b_y};
    assign aw = {5'b0, item.a_w};
    assign ah = {5'b0, item.a_h};
    assign bw = {5'b0, item.b_w};
    assign bh = {5'b0, item.b_h};

    // circle versus circle
    assign dx0 = ax - bx;
    assign dy0 = ay - by;
    assign rs  = aw + bw;
    assign mx0 = abs36(dx0);
    assign my0 = abs36(dy0);

    // circle versus box: nearest point on the box
    assign x0  = bx - (bw >>> 1);
    assign x1  = x0 + bw;
    assign y0  = by - (bh >>> 1);
    assign y1  = y0 + bh;
    assign cx  = (ax < x0) ? x0 : ((ax > x1) ? x1 : ax);
    assign cy  = (ay < y0) ? y0 : ((ay > y1) ? y1 : ay);
    assign dx1 = ax - cx;
    assign dy1 = ay - cy;
    assign mx1 = abs36(dx1);
    assign my1 = abs36(dy1);
    assign far = (mx1[35:31] != 5'd0) || (my1[35:31] != 5'd0);

    // box versus box at doubled scale
    assign ax2 = ax <<< 1;
    assign ay2 = ay <<< 1;
    assign bx2 = bx <<< 1;
    assign by2 = by <<< 1;
    assign bb_hit = !((ax2 - aw) >= (bx2 + bw)) && !((ax2 + aw) <= (bx2 - bw)) &&
                    !((ay2 - ah) >= (by2 + bh)) && !((ay2 + ah) <= (by2 - bh));
    assign vx  = (ax > bx) ? (bx2 + bw - ax2 + aw) : (bx2 - bw - ax2 - aw);
    assign vy  = (ay > by) ? (by2 + bh - ay2 + ah) : (by2 - bh - ay2 - ah);
    assign hpx = sat32((abs36(vx) + 36'd1) >> 1, vx[35]);
    assign hpy = sat32((abs36(vy) + 36'd1) >> 1, vy[35]);

    always_comb
    begin
        job      = '0;
        job.want = item.want_push;
        case (item.func)
            FUNC_CC:
            begin
                job.circ  = 1'b1;
                job.neg_x = dx0[35];
                job.neg_y = dy0[35];
                job.mx    = mx0[31:0];
                job.my    = my0[31:0];
                job.r     = rs[31:0];
            end
            FUNC_CB:
            begin
                if (far)
                begin
                    job.bypass = 1'b1;
                end
                else
                begin
                    job.circ  = 1'b1;
                    job.neg_x = dx1[35];
                    job.neg_y = dy1[35];
                    job.mx    = mx1[31:0];
                    job.my    = my1[31:0];
                    job.r     = aw[31:0];
                end
            end
            FUNC_BB:
            begin
                job.bypass = 1'b1;
                job.hit_b  = bb_hit;
                job.px_b   = (bb_hit && item.want_push) ? hpx : 32'd0;
                job.py_b   = (bb_hit && item.want_push) ? hpy : 32'd0;
            end
            default:
            begin
                job.bypass = 1'b1;
            end
        endcase
    end

endmodule

>>> sv/sop_sqrt.sv
// pipelined square root, one result bit per stage, floor root and remainder
module sop_sqrt
    import sop_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] v,
    output logic [31:0] root,
    output logic [33:0] rem
);

    logic [33:0] rem_reg  [SQ_N];
    logic [31:0] root_reg [SQ_N];
    logic [63:0] val_reg  [SQ_N];

    for (genvar k = 0; k < SQ_N; k++)
    begin : g_st
        logic [33:0] rem_in;
        logic [31:0] root_in;
        logic [63:0] val_in;
        logic [34:0] rem_sh, trial;

        if (k == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign val_in  = v;
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign val_in  = val_reg[k-1];
        end

        assign rem_sh = {rem_in[32:0], val_in[63:62]};
        assign trial  = {1'b0, root_in, 2'b01};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rem_sh >= trial)
                begin
                    rem_reg[k]  <= 34'(rem_sh - trial);
                    root_reg[k] <= {root_in[30:0], 1'b1};
                end
                else
                begin
                    rem_reg[k]  <= rem_sh[33:0];
                    root_reg[k] <= {root_in[30:0], 1'b0};
                end
                val_reg[k] <= {val_in[61:0], 2'b00};
            end
        end
    end

    assign root = root_reg[SQ_N-1];
    assign rem  = rem_reg[SQ_N-1];

endmodule

>>> sv/sop_div.sv
// pipelined restoring divider, one quotient bit per stage, high half taken as the starting remainder
module sop_div
    import sop_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] num,
    input  logic [32:0] den,
    output logic [31:0] quo,
    output logic [32:0] rem
);

    logic [32:0] rem_reg [DV_N];
    logic [31:0] lo_reg  [DV_N];
    logic [31:0] q_reg   [DV_N];
    logic [32:0] den_reg [DV_N];

    for (genvar k = 0; k < DV_N; k++)
    begin : g_st
        logic [32:0] rem_in, den_in;
        logic [31:0] lo_in, q_in;
        logic [33:0] t;

        if (k == 0)
        begin : g_first
            assign rem_in = {1'b0, num[63:32]};
            assign lo_in  = num[31:0];
            assign q_in   = '0;
            assign den_in = den;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign lo_in  = lo_reg[k-1];
            assign q_in   = q_reg[k-1];
            assign den_in = den_reg[k-1];
        end

        assign t = {rem_in, lo_in[31]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (t >= {1'b0, den_in})
                begin
                    rem_reg[k] <= 33'(t - {1'b0, den_in});
                    q_reg[k]   <= {q_in[30:0], 1'b1};
                end
                else
                begin
                    rem_reg[k] <= t[32:0];
                    q_reg[k]   <= {q_in[30:0], 1'b0};
                end
                lo_reg[k]  <= {lo_in[30:0], 1'b0};
                den_reg[k] <= den_in;
            end
        end
    end

    assign quo = q_reg[DV_N-1];
    assign rem = rem_reg[DV_N-1];

endmodule

>>> sv/sop_back.sv
// back end: squares, root, scaled division and rounding for circle pushes
module sop_back
    import sop_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  sop_job_t in_job,
    output logic     take,
    output logic     out_valid,
    output sop_out_t out_res,
    input  logic     pop
);

    logic                en;
    logic [PIPE_N-1:0]   vld_reg;
    logic                out_valid_reg;
    sop_out_t            out_reg, out_next;

    sop_job_t            a_job_reg;
    logic [63:0]         sx_reg, sy_reg, rsq_reg;
    logic [64:0]         dsq_a;
    sop_trk_t            b_trk_reg, b_trk_next;
    logic [63:0]         dsq_b_reg;
    sop_trk_t            sq_trk_reg [SQ_N];
    sop_trk_t            c_trk_reg, c_trk_next, d_trk_reg, d_trk_next;
    sop_trk_t            dv_trk_reg [DV_N];
    sop_trk_t            t;
    logic [31:0]         root, depth, qx, qy;
    logic [33:0]         srem;
    logic [63:0]         numx_reg, numy_reg;
    logic [32:0]         rx, ry, magx33, magy33;
    logic [35:0]         magx, magy;
    logic                upx, upy, push_ok;

    assign en        = !out_valid_reg || pop;
    assign take      = en;
    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

    assign dsq_a = {1'b0, sx_reg} + {1'b0, sy_reg};

    always_comb
    begin
        b_trk_next      = '0;
        b_trk_next.job  = a_job_reg;
        b_trk_next.chit = a_job_reg.circ && (dsq_a < {1'b0, rsq_reg});
    end

    sop_sqrt u_sqrt (
        .clk  (clk),
        .en   (en),
        .v    (dsq_b_reg),
        .root (root),
        .rem  (srem)
    );

    // round the root to nearest
    always_comb
    begin
        c_trk_next      = sq_trk_reg[SQ_N-1];
        c_trk_next.dlen = {1'b0, root} + 33'((srem > {2'b00, root}) ? 1 : 0);
    end

    assign depth = 32'({1'b0, c_trk_reg.job.r} - c_trk_reg.dlen);

    // quotients of 2^32 or more saturate whatever the low bits
    always_comb
    begin
        d_trk_next     = d_trk_reg;
        d_trk_next.ovx = {1'b0, numx_reg[63:32]} >= d_trk_reg.dlen;
        d_trk_next.ovy = {1'b0, numy_reg[63:32]} >= d_trk_reg.dlen;
    end

    sop_div u_div_x (
        .clk (clk),
        .en  (en),
        .num (numx_reg),
        .den (d_trk_reg.dlen),
        .quo (qx),
        .rem (rx)
    );

    sop_div u_div_y (
        .clk (clk),
        .en  (en),
        .num (numy_reg),
        .den (d_trk_reg.dlen),
        .quo (qy),
        .rem (ry)
    );

    always_comb
    begin
        t       = dv_trk_reg[DV_N-1];
        upx     = {rx, 1'b0} >= {1'b0, t.dlen};
        upy     = {ry, 1'b0} >= {1'b0, t.dlen};
        magx33  = {1'b0, qx} + 33'(upx);
        magy33  = {1'b0, qy} + 33'(upy);
        magx    = t.ovx ? '1 : {3'b000, magx33};
        magy    = t.ovy ? '1 : {3'b000, magy33};
        push_ok = t.chit && t.job.want && (t.dlen != 33'd0);
        if (t.job.bypass)
        begin
            out_next.hit    = t.job.hit_b;
            out_next.push_x = t.job.px_b;
            out_next.push_y = t.job.py_b;
        end
        else
        begin
            out_next.hit    = t.chit;
            out_next.push_x = push_ok ? sat32(magx, t.job.neg_x) : 32'd0;
            out_next.push_y = push_ok ? sat32(magy, t.job.neg_y) : 32'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[PIPE_N-2:0], in_valid};
            out_valid_reg <= vld_reg[PIPE_N-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_job_reg <= in_job;
            sx_reg    <= in_job.mx * in_job.mx;
            sy_reg    <= in_job.my * in_job.my;
            rsq_reg   <= in_job.r * in_job.r;
            b_trk_reg <= b_trk_next;
            dsq_b_reg <= dsq_a[63:0];
            sq_trk_reg[0] <= b_trk_reg;
            for (int k = 1; k < SQ_N; k++)
                sq_trk_reg[k] <= sq_trk_reg[k-1];
            c_trk_reg <= c_trk_next;
            d_trk_reg <= c_trk_reg;
            numx_reg  <= depth * c_trk_reg.job.mx;
            numy_reg  <= depth * c_trk_reg.job.my;
            dv_trk_reg[0] <= d_trk_next;
            for (int k = 1; k < DV_N; k++)
                dv_trk_reg[k] <= dv_trk_reg[k-1];
            out_reg <= out_next;
        end
    end

endmodule

>>> sv/shape_overlap_push_unit.sv
// top level of the shape overlap push unit: input queue, front end and back end
// One shape pair is taken per clock and one result leaves per clock when pop is
// held; the pipeline is fully overlapped, so many pairs are in flight at once.
// A pair's result passes through the 32-stage square root and the 32-stage push
// divider in the back end. Box-box and non-hitting pairs ride the same pipeline,
// so results leave in order. A two-entry queue behind the front end lets the
// input side keep taking pairs until the queue fills while the result side stalls.
module shape_overlap_push_unit
    import sop_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    output logic     full,
    input  sop_in_t  item,
    output logic     empty,
    input  logic     pop,
    output sop_out_t result
);

    sop_job_t    front_job;
    sop_job_t    q_reg [2];
    logic [1:0]  count_reg, count_next;
    logic        wr_reg, rd_reg;
    logic        wr_en, rd_en, take, out_valid;

    // classify the pair and finish box tests on the way in
    sop_front u_front (
        .item (item),
        .job  (front_job)
    );

    assign full  = (count_reg == 2'd2);
    assign wr_en = push && !full;
    // back end takes the queue head whenever its pipeline advances and the queue is not empty
    assign rd_en = take && (count_reg != 2'd0);

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
            count_next = count_reg + 2'd1;
        else if (!wr_en && rd_en)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
            wr_reg    <= 1'b0;
            rd_reg    <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (wr_en)
                wr_reg <= !wr_reg;
            if (rd_en)
                rd_reg <= !rd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            q_reg[wr_reg] <= front_job;
    end

    sop_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rd_en),
        .in_job    (q_reg[rd_reg]),
        .take      (take),
        .out_valid (out_valid),
        .out_res   (result),
        .pop       (pop)
    );

    assign empty = !out_valid;

endmodule

>>> sv/sop_checker.sv
// port-level checker for the shape overlap push unit, bound to the top level
`include "shape_overlap_push_unit_macros.svh"

module sop_checker
    import sop_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     push,
    input logic     full,
    input sop_in_t  item,
    input logic     empty,
    input logic     pop,
    input sop_out_t result
);

    // a waiting result holds until its transfer
    `SOP_ASSERT_NXT(a_hold, !empty && !pop, !empty && $stable(result))
    // a miss never carries a push
    `SOP_ASSERT_IMP(a_miss_zero, !empty && !result.hit, result.push_x == 32'd0 && result.push_y == 32'd0)
    // leaving reset the unit is drained and open
    `SOP_ASSERT_IMP(a_reset_clean, $rose(rst_n), empty && !full)

endmodule

bind shape_overlap_push_unit sop_checker u_sop_checker (.*);
